/* rtl/gcr_disk_read_stream_unit_assert.svh */
// Assertion macros for the disk read stream unit
`ifndef GCR_DISK_READ_STREAM_UNIT_ASSERT_SVH
`define GCR_DISK_READ_STREAM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GCRDRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcrdrs assertion failed");
`define GCRDRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcrdrs assertion failed");
`else
`define GCRDRS_ASSERT_IMP(lbl, ante, cons)
`define GCRDRS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/gcrdrs_pkg.sv */
// Shared constants, types and group-code functions for the disk read stream unit
package gcrdrs_pkg;

    localparam int TICKS_PER_BYTE = 26;
    localparam int FRAME_BYTES    = 295;
    localparam int SECTOR_COUNT   = 2;
    localparam int SECTOR_BYTES   = 256;

    localparam int PHASE_W = $clog2(TICKS_PER_BYTE);
    localparam int POS_W   = $clog2(FRAME_BYTES);
    localparam int Q_W     = $clog2(FRAME_BYTES / 5 + 1);
    localparam int SEC_W   = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int GRP_W   = $clog2(SECTOR_BYTES / 4);
    localparam int ROW_W   = SEC_W + GRP_W;
    localparam int ROWS    = SECTOR_COUNT * SECTOR_BYTES / 4;

    localparam int SYNC_A_END  = 5;
    localparam int HDR_END     = 15;
    localparam int SYNC_B_BEG  = 25;
    localparam int DATA_BEG    = 30;
    localparam int DATA_END    = 290;
    localparam int DATA_Q_BEG  = DATA_BEG / 5;
    localparam int HDR_Q_TWO   = 2;

    localparam logic [7:0] HDR_ID   = 8'h08;
    localparam logic [7:0] HDR_PAD  = 8'h0A;
    localparam logic [7:0] HDR_TAIL = 8'h0F;
    localparam logic [7:0] GAP_BYTE = 8'hFF;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [3:0][7:0] t_row;

    typedef struct packed {
        logic [2:0]       k;
        logic             sync;
        logic             hdr;
        logic             hdr_two;
        logic             dat;
        logic             ready;
        logic [5:0]       track;
        logic [SEC_W-1:0] sector;
    } t_tick_info;

    function automatic logic [4:0] code5(input logic [3:0] nib);
        logic [4:0] c;
        case (nib)
            4'h0: c = 5'h0A;  4'h1: c = 5'h0B;  4'h2: c = 5'h12;  4'h3: c = 5'h13;
            4'h4: c = 5'h0E;  4'h5: c = 5'h0F;  4'h6: c = 5'h16;  4'h7: c = 5'h17;
            4'h8: c = 5'h09;  4'h9: c = 5'h19;  4'hA: c = 5'h1A;  4'hB: c = 5'h1B;
            4'hC: c = 5'h0D;  4'hD: c = 5'h1D;  4'hE: c = 5'h1E;  default: c = 5'h15;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] coded_byte(input logic [2:0] k, input t_row g);
        logic [39:0] bits;
        logic [7:0]  r;
        bits = {code5(g[0][7:4]), code5(g[0][3:0]), code5(g[1][7:4]), code5(g[1][3:0]),
                code5(g[2][7:4]), code5(g[2][3:0]), code5(g[3][7:4]), code5(g[3][3:0])};
        case (k)
            3'd0:    r = bits[39:32];
            3'd1:    r = bits[31:24];
            3'd2:    r = bits[23:16];
            3'd3:    r = bits[15:8];
            default: r = bits[7:0];
        endcase
        return r;
    endfunction

endpackage

/* rtl/gcrdrs_store.sv */
// Sector store: word memory of 4-byte rows with per-row valid bits
module gcrdrs_store import gcrdrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [ROW_W-1:0] i_wr_row,
    input  logic [1:0]       i_wr_lane,
    input  logic [7:0]       i_wr_data,
    input  logic             i_rd_en,
    input  logic [ROW_W-1:0] i_rd_row,
    output t_row             o_rd_data
);

    t_row            r_mem [0:ROWS-1];
    logic [ROWS-1:0] r_valid;
    t_row            r_rd_data;
    logic            r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int l = 0; l < 4; l++) begin
                if (l == int'(i_wr_lane)) begin
                    r_mem[i_wr_row][l] <= i_wr_data;
                end else if (!r_valid[i_wr_row]) begin
                    r_mem[i_wr_row][l] <= 8'h00;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_row];
            r_rd_valid <= r_valid[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* rtl/gcrdrs_seq.sv */
// Head timing: tick phase, frame position, sector and byte-ready tracking
module gcrdrs_seq import gcrdrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tick,
    input  logic [5:0]       i_track,
    input  logic             i_soe,
    output t_tick_info       o_info,
    output logic [ROW_W-1:0] o_rd_row
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [Q_W-1:0]     r_q, n_q;
    logic [2:0]         r_k, n_k;
    logic [SEC_W-1:0]   r_sector, n_sector;
    logic               r_prev_soe;
    logic               edge_hit;
    logic [PHASE_W:0]   phase_inc;
    logic [POS_W:0]     pos_inc;
    logic [SEC_W:0]     sec_inc;
    logic [Q_W-1:0]     grp;

    always_comb begin
        phase_inc = {1'b0, r_phase} + 1'b1;
        pos_inc   = {1'b0, r_pos} + 1'b1;
        sec_inc   = {1'b0, r_sector} + 1'b1;
        n_phase   = phase_inc[PHASE_W-1:0];
        n_pos     = r_pos;
        n_q       = r_q;
        n_k       = r_k;
        n_sector  = r_sector;
        edge_hit  = 1'b0;
        if (phase_inc >= (PHASE_W+1)'(TICKS_PER_BYTE)) begin
            n_phase  = '0;
            edge_hit = 1'b1;
            if (pos_inc >= (POS_W+1)'(FRAME_BYTES)) begin
                n_pos = '0;
                n_q   = '0;
                n_k   = '0;
                n_sector = (sec_inc >= (SEC_W+1)'(SECTOR_COUNT)) ? '0 : sec_inc[SEC_W-1:0];
            end else begin
                n_pos = pos_inc[POS_W-1:0];
                if (r_k == 3'd4) begin
                    n_k = '0;
                    n_q = r_q + 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_pos      <= '0;
            r_q        <= '0;
            r_k        <= '0;
            r_sector   <= '0;
            r_prev_soe <= 1'b1;
        end else if (i_tick) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_q        <= n_q;
            r_k        <= n_k;
            r_sector   <= n_sector;
            r_prev_soe <= i_soe;
        end
    end

    always_comb begin
        o_info.k       = n_k;
        o_info.sync    = (n_pos < POS_W'(SYNC_A_END)) ||
                         (n_pos >= POS_W'(SYNC_B_BEG) && n_pos < POS_W'(DATA_BEG));
        o_info.hdr     = (n_pos >= POS_W'(SYNC_A_END)) && (n_pos < POS_W'(HDR_END));
        o_info.hdr_two = (n_q == Q_W'(HDR_Q_TWO));
        o_info.dat     = (n_pos >= POS_W'(DATA_BEG)) && (n_pos < POS_W'(DATA_END));
        o_info.ready   = (edge_hit || !r_prev_soe) && !o_info.sync;
        o_info.track   = i_track;
        o_info.sector  = n_sector;
        grp            = n_q - Q_W'(DATA_Q_BEG);
        o_rd_row       = {n_sector, grp[GRP_W-1:0]};
    end

endmodule

/* rtl/gcr_disk_read_stream_unit.sv */
// Top level of the disk read stream unit: handshake, coding stage and output register
//
//  channel | dir | tdata                                        | tuser
//  s       | in  | track[5:0] soe[6] wsec[7] widx[15:8] wval[23:16] | op
//  m       | out | read_byte[7:0]                               | sync[0] ready[1]
//
//  One word per cycle unless the output stalls; a tick word registers its store read
//  and tick info at its accepting edge, then its coded byte in the output register.
//  Write words give no output.
//  Reset clears the counters and the row valid bits at once; no clearing pass.
//  A stalled output holds the whole pipe and drops s tready.
module gcr_disk_read_stream_unit import gcrdrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // track, soe, write_sector, write_index, write_value
    input  logic        i_s_tuser,   // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // read_byte
    output logic [1:0]  o_m_tuser    // sync_active, byte_ready
);

`include "gcr_disk_read_stream_unit_assert.svh"

    logic             advance;
    logic             acc;
    logic             acc_tick;
    logic             acc_write;
    t_tick_info       info;
    logic [ROW_W-1:0] rd_row;
    t_row             rd_data;
    t_row             group;
    logic [7:0]       coded;
    logic [5:0]       hdr_sec;

    t_tick_info       r_b_info;
    logic             r_b_valid;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_sync;
    logic             r_out_ready;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = advance;
    assign acc        = i_s_tvalid && advance;
    assign acc_tick   = acc && (i_s_tuser == OP_TICK);
    assign acc_write  = acc && (i_s_tuser == OP_WRITE);

    gcrdrs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (acc_tick),
        .i_track  (i_s_tdata[5:0]),
        .i_soe    (i_s_tdata[6]),
        .o_info   (info),
        .o_rd_row (rd_row)
    );

    gcrdrs_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (acc_write),
        .i_wr_row  ({i_s_tdata[7 -: SEC_W], i_s_tdata[15 -: GRP_W]}),
        .i_wr_lane (i_s_tdata[9:8]),
        .i_wr_data (i_s_tdata[23:16]),
        .i_rd_en   (acc_tick),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data)
    );

    always_comb begin
        hdr_sec = 6'(r_b_info.sector);
        if (r_b_info.hdr) begin
            if (r_b_info.hdr_two) begin
                group = {HDR_TAIL, HDR_TAIL, {2'b00, r_b_info.track ^ hdr_sec}, HDR_PAD};
            end else begin
                group = {HDR_PAD, {2'b00, hdr_sec}, {2'b00, r_b_info.track}, HDR_ID};
            end
        end else begin
            group = rd_data;
        end
        coded = (r_b_info.hdr || r_b_info.dat) ? coded_byte(r_b_info.k, group) : GAP_BYTE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid   <= acc_tick;
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_info    <= info;
            r_out_byte  <= coded;
            r_out_sync  <= r_b_info.sync;
            r_out_ready <= r_b_info.ready;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = {r_out_ready, r_out_sync};

    `GCRDRS_ASSERT_IMP(a_sync_not_ready, o_m_tvalid && o_m_tuser[0], !o_m_tuser[1])
    `GCRDRS_ASSERT_IMP(a_sync_gap_byte, o_m_tvalid && o_m_tuser[0], o_m_tdata == GAP_BYTE)
    `GCRDRS_ASSERT_NXT(a_write_no_result, acc_write, !r_b_valid)
    `GCRDRS_ASSERT_NXT(a_tick_enters, acc_tick, r_b_valid)

endmodule
